[hw/rtl/cua_pkg.sv]
// Package with constants, types and codes shared by the contiguous unit allocator.
package cua_pkg;
    localparam int UNITS     = 64;
    localparam int SLOTS     = 64;
    localparam int LIFE_BITS = 16;
    localparam int UNIT_W    = $clog2(UNITS);
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(UNITS + 1);
    localparam int SCNT_W    = $clog2(SLOTS + 1);

    typedef logic [1:0] policy_t;
    localparam policy_t POL_BEST  = 2'd0;
    localparam policy_t POL_FIRST = 2'd1;
    localparam policy_t POL_NEXT  = 2'd2;
    localparam policy_t POL_WORST = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_GRANT = 2'd0;
    localparam status_t ST_NOFIT = 2'd1;
    localparam status_t ST_TICK  = 2'd2;

    localparam logic [0:0] REG_FIT_POLICY = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN2,
        S_FILL,
        S_TICK,
        S_DONE
    } state_t;

    // Slot table entry: start, length, remaining life.
    localparam int ENTRY_W = UNIT_W + CNT_W + LIFE_BITS;
endpackage

[hw/rtl/cua_ram.sv]
// Generic single-port RAM with registered read data.
module cua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[hw/rtl/contiguous_unit_allocator.sv]
// Top level of the contiguous unit allocator: handshakes, sequencer, unit map and slot table.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | s_valid s_ready s_opcode s_request_*    | in
//  result  | m_valid m_ready m_status m_start_unit.. | out
//  config  | psel penable pwrite paddr pwdata prdata | in/out
//
// Allocate: the scan checks one unit per cycle across the map, wrapping back to unit 0 for next fit,
// then the map is marked for the granted units, one unit per cycle.
// Tick: each slot is read from the slot-table RAM and valid slots are written back,
// and the units of each expiring run are cleared, one unit per cycle.
// Reset clears the unit map and slot valid bits at once; slot RAM needs no clear.
// The block takes one request at a time; a waiting result stalls the next request.
module contiguous_unit_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [6:0]                     s_request_size,
    input  logic [15:0]                    s_request_duration,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cua_pkg::status_t               m_status,
    output logic [5:0]                     m_start_unit,
    output logic [5:0]                     m_slot_handle,
    output logic [6:0]                     m_freed_count,
    output logic [6:0]                     m_free_units,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [0:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import cua_pkg::*;

    state_t state_reg, state_next;
    policy_t policy_reg;

    logic [UNITS-1:0]  occ_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [UNIT_W-1:0] nfp_reg;
    logic [CNT_W-1:0]  free_reg;

    logic [CNT_W-1:0]     size_reg;
    logic [LIFE_BITS-1:0] dur_reg;
    logic                 op_reg;

    // scan state
    logic [CNT_W-1:0]  idx_reg;        // scan position, 0..UNITS
    logic [CNT_W-1:0]  end_reg;        // scan end for this pass
    logic [CNT_W-1:0]  run_reg;        // current free run length
    logic [UNIT_W-1:0] run_start_reg;
    logic              found_reg;
    logic [UNIT_W-1:0] pick_reg;
    logic [CNT_W-1:0]  pick_len_reg;
    logic              wrap_reg;       // second next-fit pass under way
    logic [SLOT_W-1:0] slot_reg;

    // fill / clear
    logic [UNIT_W-1:0] fpos_reg;
    logic [CNT_W-1:0]  fleft_reg;
    logic              fset_reg;

    // tick walk
    logic [SCNT_W-1:0] tslot_reg;
    logic              tphase_reg;
    logic [SCNT_W-1:0] freed_reg;

    // result
    logic              mvalid_reg;
    status_t           mstatus_reg;
    logic [UNIT_W-1:0] mstart_reg;
    logic [SLOT_W-1:0] mhandle_reg;
    logic [6:0]        mfreed_reg;

    // slot RAM
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    cua_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic [UNIT_W-1:0]    e_start;
    logic [CNT_W-1:0]     e_len;
    logic [LIFE_BITS-1:0] e_rem, e_rem_dec;
    assign {e_start, e_len, e_rem} = ram_rdata;
    assign e_rem_dec = e_rem - 1'b1;

    // lowest free slot
    logic              any_free_slot;
    logic [SLOT_W-1:0] low_free_slot;
    always_comb begin
        any_free_slot = 1'b0;
        low_free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                any_free_slot = 1'b1;
                low_free_slot = SLOT_W'(i);
            end
        end
    end

    // scan unit: one unit per cycle
    logic [UNIT_W-1:0] idx_u;
    logic              unit_free;
    logic [CNT_W-1:0]  run_new;
    logic [UNIT_W-1:0] rs_new;
    logic              hole_mode;
    logic              hole_end;
    logic              better;
    logic              fit_hit;
    assign idx_u     = idx_reg[UNIT_W-1:0];
    assign unit_free = !occ_reg[idx_u];
    assign run_new   = unit_free ? run_reg + 1'b1 : '0;
    assign rs_new    = (run_reg == '0) ? idx_u : run_start_reg;
    assign hole_mode = (policy_reg == POL_BEST) || (policy_reg == POL_WORST);
    // hole closes at an occupied unit or at the last unit
    assign hole_end  = (!unit_free && run_reg != '0) ||
                       (unit_free && idx_reg == CNT_W'(UNITS - 1));
    logic [CNT_W-1:0]  hole_len;
    logic [UNIT_W-1:0] hole_start;
    assign hole_len   = unit_free ? run_new : run_reg;
    assign hole_start = unit_free ? rs_new : run_start_reg;
    assign better = !found_reg ||
                    ((policy_reg == POL_WORST) ? hole_len > pick_len_reg
                                               : hole_len < pick_len_reg);
    // first/next fit: a run reaching size ends at idx; it started at idx-size+1
    assign fit_hit = unit_free && run_new == size_reg;

    logic [UNIT_W-1:0] fit_start;
    assign fit_start = UNIT_W'(idx_reg + 1'b1 - size_reg);

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_FIT_POLICY);
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FIT_POLICY) ? {30'd0, policy_reg} : 32'd0;

    assign s_ready       = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_valid       = mvalid_reg;
    assign m_status      = mstatus_reg;
    assign m_start_unit  = mstart_reg;
    assign m_slot_handle = mhandle_reg;
    assign m_freed_count = mfreed_reg;
    assign m_free_units  = free_reg;

    logic in_acc;
    assign in_acc = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        ram_we    = 1'b0;
        ram_addr  = tslot_reg[SLOT_W-1:0];
        ram_wdata = {e_start, e_len, e_rem_dec};
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_opcode == OP_TICK) begin
                        state_next = S_TICK;
                    end else if (s_request_size == '0 || !any_free_slot) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!hole_mode && fit_hit) begin
                    state_next = S_FILL;
                end else if (idx_reg + 1'b1 >= end_reg) begin
                    if (hole_mode) begin
                        state_next = (found_reg || (hole_end && hole_len >= size_reg))
                                     ? S_FILL : S_DONE;
                    end else if (policy_reg == POL_NEXT && !wrap_reg
                                 && nfp_reg != '0) begin
                        state_next = S_SCAN2;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN2: state_next = S_SCAN;
            S_FILL: begin
                if (fset_reg) begin
                    ram_we    = 1'b1;
                    ram_addr  = slot_reg;
                    ram_wdata = {pick_reg, size_reg, dur_reg};
                end
                if (fleft_reg <= CNT_W'(1)) begin
                    state_next = fset_reg ? S_DONE : S_TICK;
                end
            end
            S_TICK: begin
                if (tslot_reg == SCNT_W'(SLOTS)) begin
                    state_next = S_DONE;
                end else if (tphase_reg && valid_reg[tslot_reg[SLOT_W-1:0]]) begin
                    ram_we = 1'b1;
                    if (e_rem_dec == '0) begin
                        state_next = S_FILL;
                    end
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            policy_reg <= POL_FIRST;
            occ_reg    <= '0;
            valid_reg  <= '0;
            nfp_reg    <= '0;
            free_reg   <= CNT_W'(UNITS);
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                policy_reg <= pwdata[1:0];
            end
            if (mvalid_reg && m_ready) begin
                mvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        op_reg        <= s_opcode;
                        size_reg      <= s_request_size;
                        dur_reg       <= (s_request_duration[LIFE_BITS-1:0] == '0)
                                         ? LIFE_BITS'(1) : s_request_duration[LIFE_BITS-1:0];
                        wrap_reg      <= 1'b0;
                        slot_reg      <= low_free_slot;
                        found_reg     <= 1'b0;
                        pick_reg      <= '0;
                        pick_len_reg  <= '0;
                        run_reg       <= '0;
                        run_start_reg <= '0;
                        tslot_reg     <= '0;
                        tphase_reg    <= 1'b0;
                        freed_reg     <= '0;
                        if (policy_reg == POL_NEXT) begin
                            idx_reg <= CNT_W'(nfp_reg);
                        end else begin
                            idx_reg <= '0;
                        end
                        end_reg <= CNT_W'(UNITS);
                    end
                end
                S_SCAN: begin
                    idx_reg       <= idx_reg + 1'b1;
                    run_reg       <= run_new;
                    run_start_reg <= rs_new;
                    if (hole_mode && hole_end && hole_len >= size_reg && better) begin
                        found_reg    <= 1'b1;
                        pick_reg     <= hole_start;
                        pick_len_reg <= hole_len;
                    end
                    if (state_next == S_FILL) begin
                        fset_reg  <= 1'b1;
                        fleft_reg <= size_reg;
                        if (!hole_mode) begin
                            pick_reg <= fit_start;
                            fpos_reg <= fit_start;
                        end else if (hole_end && hole_len >= size_reg && better) begin
                            fpos_reg <= hole_start;
                        end else begin
                            fpos_reg <= pick_reg;
                        end
                    end
                end
                S_SCAN2: begin
                    // wrap: scan [0, p) with runs still bounded by p+size-1
                    wrap_reg <= 1'b1;
                    idx_reg  <= '0;
                    run_reg  <= '0;
                    end_reg  <= (CNT_W + 1)'(nfp_reg) + size_reg - 1'b1 > UNITS
                                ? CNT_W'(UNITS)
                                : CNT_W'((CNT_W + 1)'(nfp_reg) + size_reg - 1'b1);
                end
                S_FILL: begin
                    occ_reg[fpos_reg] <= fset_reg;
                    fpos_reg  <= fpos_reg + 1'b1;
                    fleft_reg <= fleft_reg - 1'b1;
                    if (fset_reg) begin
                        free_reg <= free_reg - 1'b1;
                        if (fleft_reg <= CNT_W'(1)) begin
                            valid_reg[slot_reg] <= 1'b1;
                            nfp_reg     <= pick_reg;
                            mstatus_reg <= ST_GRANT;
                            mstart_reg  <= pick_reg;
                            mhandle_reg <= slot_reg;
                        end
                    end else if (occ_reg[fpos_reg]) begin
                        free_reg <= free_reg + 1'b1;
                    end
                    if (!fset_reg && fleft_reg <= CNT_W'(1)) begin
                        tslot_reg  <= tslot_reg + 1'b1;
                        tphase_reg <= 1'b0;
                    end
                end
                S_TICK: begin
                    if (tslot_reg != SCNT_W'(SLOTS)) begin
                        if (!tphase_reg) begin
                            tphase_reg <= 1'b1;
                        end else if (valid_reg[tslot_reg[SLOT_W-1:0]] && e_rem_dec == '0) begin
                            valid_reg[tslot_reg[SLOT_W-1:0]] <= 1'b0;
                            freed_reg <= freed_reg + 1'b1;
                            fset_reg  <= 1'b0;
                            fpos_reg  <= e_start;
                            // clamp at the last unit
                            fleft_reg <= ((CNT_W + 1)'(e_start) + e_len > UNITS)
                                         ? CNT_W'(UNITS - e_start) : e_len;
                        end else begin
                            tphase_reg <= 1'b0;
                            tslot_reg  <= tslot_reg + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    mvalid_reg <= 1'b1;
                    if (op_reg == OP_TICK) begin
                        mstatus_reg <= ST_TICK;
                        mstart_reg  <= '0;
                        mhandle_reg <= '0;
                        mfreed_reg  <= 7'(freed_reg);
                    end else begin
                        mfreed_reg <= '0;
                        if (mstatus_reg != ST_GRANT || !fset_reg) begin
                            mstatus_reg <= ST_NOFIT;
                            mstart_reg  <= '0;
                            mhandle_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
            // mark a fresh request as not yet granted
            if (in_acc) begin
                mstatus_reg <= ST_NOFIT;
                fset_reg    <= 1'b0;
            end
        end
    end

    // free count matches the map whenever idle
    a_free_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (free_reg == CNT_W'(UNITS - $countones(occ_reg))))
        else $error("free count disagrees with unit map");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE && !m_valid))
        else $error("ready while busy");
    a_grant_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_GRANT) |-> valid_reg[m_slot_handle])
        else $error("granted slot not valid");
    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> m_valid)
        else $error("result not raised after done");
endmodule

[bench/contiguous_unit_allocator_tb.sv]
// Self-checking testbench for the contiguous unit allocator.
`timescale 1ns / 1ps

module contiguous_unit_allocator_tb;
    import cua_pkg::*;

    localparam int IDLE_LIMIT = 6000;

    typedef struct packed {
        status_t    status;
        logic [5:0] start_unit;
        logic [5:0] slot_handle;
        logic [6:0] freed_count;
        logic [6:0] free_units;
    } alloc_answer_t;

    class alloc_scoreboard;
        bit            unit_busy [UNITS];
        bit            slot_live [SLOTS];
        int            slot_base [SLOTS];
        int            slot_len  [SLOTS];
        logic [15:0]   slot_life [SLOTS];
        int            next_ptr;
        int            free_cnt;
        policy_t       policy;
        alloc_answer_t answers[$];
        int            errors;

        function new();
            foreach (unit_busy[i]) unit_busy[i] = 0;
            foreach (slot_live[i]) slot_live[i] = 0;
            next_ptr = 0;
            free_cnt = UNITS;
            policy   = POL_FIRST;
            errors   = 0;
        endfunction

        function bit run_free(int s, int size);
            if (s >= UNITS || size > UNITS - s) return 0;
            for (int k = s; k < s + size; k++)
                if (unit_busy[k]) return 0;
            return 1;
        endfunction

        function int scan_from(int from, int to, int size);
            for (int i = from; i < to; i++)
                if (run_free(i, size)) return i;
            return UNITS;
        endfunction

        // judge maximal holes only; ties keep the lowest address
        function int hole_fit(int size, bit want_big);
            int i, s, len, pick, pick_len;
            bit found;
            i = 0; pick = UNITS; pick_len = 0; found = 0;
            while (i < UNITS) begin
                if (unit_busy[i]) begin
                    i++;
                    continue;
                end
                s = i;
                while (i < UNITS && !unit_busy[i]) i++;
                len = i - s;
                if (len >= size && (!found ||
                        (want_big ? len > pick_len : len < pick_len))) begin
                    found = 1; pick = s; pick_len = len;
                end
            end
            return pick;
        endfunction

        function void note_request(logic op, logic [6:0] size, logic [15:0] dur);
            alloc_answer_t a;
            int slot, pos, freed;
            a = '0;
            a.status = ST_NOFIT;
            freed = 0;
            if (op == OP_TICK) begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!slot_live[s]) continue;
                    slot_life[s] = slot_life[s] - 16'd1;
                    if (slot_life[s] == 0) begin
                        for (int k = slot_base[s];
                                k < slot_base[s] + slot_len[s] && k < UNITS; k++) begin
                            if (unit_busy[k]) begin
                                unit_busy[k] = 0;
                                free_cnt++;
                            end
                        end
                        slot_live[s] = 0;
                        freed++;
                    end
                end
                a.status = ST_TICK;
            end else if (size != 0) begin
                slot = SLOTS;
                pos  = UNITS;
                for (int s = 0; s < SLOTS; s++)
                    if (!slot_live[s]) begin
                        slot = s;
                        break;
                    end
                if (slot < SLOTS) begin
                    case (policy)
                        POL_BEST:  pos = hole_fit(size, 0);
                        POL_WORST: pos = hole_fit(size, 1);
                        POL_NEXT: begin
                            pos = scan_from(next_ptr, UNITS, size);
                            if (pos >= UNITS) pos = scan_from(0, next_ptr, size);
                        end
                        default:   pos = scan_from(0, UNITS, size);
                    endcase
                end
                if (slot < SLOTS && pos < UNITS && run_free(pos, size)) begin
                    for (int k = pos; k < pos + size; k++) unit_busy[k] = 1;
                    free_cnt -= size;
                    slot_live[slot] = 1;
                    slot_base[slot] = pos;
                    slot_len[slot]  = size;
                    slot_life[slot] = (dur == 0) ? 16'd1 : dur;
                    next_ptr        = pos;
                    a.status        = ST_GRANT;
                    a.start_unit    = 6'(pos);
                    a.slot_handle   = 6'(slot);
                end
            end
            a.freed_count = 7'(freed);
            a.free_units  = 7'(free_cnt);
            answers.push_back(a);
        endfunction

        function void check_result(alloc_answer_t got);
            alloc_answer_t want;
            if (answers.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = answers.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_valid, s_ready, s_opcode;
    logic [6:0]  s_request_size;
    logic [15:0] s_request_duration;
    logic        m_valid, m_ready;
    status_t     m_status;
    logic [5:0]  m_start_unit, m_slot_handle;
    logic [6:0]  m_freed_count, m_free_units;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    alloc_scoreboard sb = new();
    int  burst_left = 0;
    bit  hold_req   = 0;

    contiguous_unit_allocator i_dut (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // hold off on request of the stimulus, else stall on a pattern of its own
    initial begin
        int hold_left;
        int phase;
        hold_left = 0;
        phase     = 0;
        m_ready   = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = 400;
            end
            phase = (phase + 1) % 200;
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 0;
            end else if (phase < 60) begin
                m_ready = 1;
            end else begin
                m_ready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk)
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_status, m_start_unit, m_slot_handle,
                             m_freed_count, m_free_units});

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(logic op, logic [6:0] size, logic [15:0] dur);
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid = 0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid            = 1;
        s_opcode           = op;
        s_request_size     = size;
        s_request_duration = dur;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, size, dur);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid    = 0;
        burst_left = 0;
        wait (sb.answers.size() == 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_policy(policy_t p);
        drain();
        psel = 1; pwrite = 1; penable = 0; paddr = REG_FIT_POLICY; pwdata = 32'(p);
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        sb.policy = p;
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic random_request();
        logic [6:0]  size;
        logic [15:0] dur;
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) begin
            send_request(OP_TICK, 7'($urandom_range(0, 127)), 16'($urandom));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 85) size = 7'($urandom_range(1, 12));
        else if (r < 93) size = 7'($urandom_range(13, 64));
        else size = 7'($urandom_range(0, 127));
        dur = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        send_request(OP_ALLOC, size, dur);
    endtask

    initial begin
        policy_t plan[6] = '{POL_BEST, POL_NEXT, POL_WORST, POL_FIRST, POL_WORST, POL_BEST};
        aresetn = 0;
        s_valid = 0; s_opcode = OP_ALLOC; s_request_size = 0; s_request_duration = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: default first fit
        send_request(OP_ALLOC, 7'd64, 16'd2);
        send_request(OP_ALLOC, 7'd1, 16'd5);
        send_request(OP_TICK, 7'd0, 16'd0);
        send_request(OP_TICK, 7'd127, 16'hFFFF);
        send_request(OP_ALLOC, 7'd0, 16'd3);
        send_request(OP_ALLOC, 7'd127, 16'd1);
        send_request(OP_ALLOC, 7'd65, 16'd1);
        send_request(OP_ALLOC, 7'd3, 16'd0);
        send_request(OP_TICK, 7'd0, 16'd0);
        send_request(OP_ALLOC, 7'd63, 16'd4);
        send_request(OP_ALLOC, 7'd1, 16'd1);
        send_request(OP_TICK, 7'd0, 16'd0);
        send_request(OP_ALLOC, 7'd2, 16'd1);
        send_request(OP_ALLOC, 7'd1, 16'hFFFF);
        repeat (4) send_request(OP_TICK, 7'd0, 16'd0);

        for (int ph = 0; ph < 6; ph++) begin
            write_policy(plan[ph]);
            if (ph == 1) begin
                // fill every slot with single units, then one too many
                repeat (65) send_request(OP_ALLOC, 7'd1, 16'($urandom_range(1, 3)));
                repeat (4) send_request(OP_TICK, 7'd0, 16'd0);
            end
            if (ph == 2) hold_req = 1;
            repeat (55) random_request();
            // three extra ticks let live runs age and expire
            repeat (3) send_request(OP_TICK, 7'd0, 16'd0);
        end

        drain();
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.answers.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
hw/rtl/cua_pkg.sv
hw/rtl/cua_ram.sv
hw/rtl/contiguous_unit_allocator.sv
bench/contiguous_unit_allocator_tb.sv
